@@ rtl/soa_pkg.sv @@
`timescale 1ns / 1ps

package soa_pkg;

    localparam int ADDR_W     = 16;
    localparam int OP_W       = 1;
    localparam int SIZE_W     = 10;
    localparam int CNT_W      = 12;
    localparam int SIZE_RESET = 16;
    localparam int MIN_SIZE   = 2;

    localparam int PAGE_BYTES_DEF = 4096;
    localparam int POOL_PAGES_DEF = 16;
    localparam int SLOT_AREA_DEF  = 4064;

    localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_ACCEPT,
        CMD_SCAN_NEXT,
        CMD_FAIL,
        CMD_FORM_START,
        CMD_FORM_STEP,
        CMD_FORM_END,
        CMD_RD_HEAD,
        CMD_A_REC,
        CMD_A_COMMIT,
        CMD_RD_T,
        CMD_WR_PREV_NONE,
        CMD_RD_P,
        CMD_F_REC,
        CMD_WR_PREV_P,
        CMD_RELEASE,
        CMD_RD_V,
        CMD_RD_N,
        CMD_WR_NEXT_N,
        CMD_WR_PREV_REL,
        CMD_LOAD_OUT
    } cmd_t;

    typedef struct packed {
        logic op_free;
        logic free_ok;
        logic list_empty;
        logic scan_end;
        logic scan_free;
        logic form_more;
        logic was_end;
        logic h_valid;
        logic new_end;
        logic n_valid;
        logic v_valid;
        logic zero;
        logic p_is_head;
        logic out_space;
    } flags_t;

endpackage

@@ rtl/soa_channels.sv @@
`timescale 1ns / 1ps

interface soa_req_if;
    logic                         valid;
    logic                         ready;
    logic [soa_pkg::OP_W-1:0]     operation;
    logic [soa_pkg::ADDR_W-1:0]   address;
    modport source (output valid, output operation, output address, input ready);
    modport sink   (input valid, input operation, input address, output ready);
endinterface

interface soa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [soa_pkg::ADDR_W-1:0]   object_address;
    logic                         status;
    logic                         page_taken;
    logic                         page_released;
    modport source (output valid, output object_address, output status,
                    output page_taken, output page_released, input ready);
    modport sink   (input valid, input object_address, input status,
                    input page_taken, input page_released, output ready);
endinterface

interface soa_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [soa_pkg::SIZE_W-1:0]   object_size;
    modport source (output valid, output object_size, input ready);
    modport sink   (input valid, input object_size, output ready);
endinterface

@@ rtl/soa_ram.sv @@
`timescale 1ns / 1ps

module soa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [WIDTH-1:0]      wdata,
    input  logic [AW-1:0]         raddr,
    output logic [WIDTH-1:0]      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/soa_ctrl.sv @@
`timescale 1ns / 1ps

module soa_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  soa_pkg::flags_t flags,
    output soa_pkg::cmd_t   cmd
);
    typedef enum logic [17:0] {
        ST_IDLE     = 18'h00001,
        ST_DISPATCH = 18'h00002,
        ST_SCAN     = 18'h00004,
        ST_FORM     = 18'h00008,
        ST_A_RD     = 18'h00010,
        ST_A_REC    = 18'h00020,
        ST_A_NFO    = 18'h00040,
        ST_A_LRD    = 18'h00080,
        ST_A_LWR    = 18'h00100,
        ST_F_REC    = 18'h00200,
        ST_F_HRD    = 18'h00400,
        ST_F_HWR    = 18'h00800,
        ST_F_CHK    = 18'h01000,
        ST_F_VRD    = 18'h02000,
        ST_F_VWR    = 18'h04000,
        ST_F_NRD    = 18'h08000,
        ST_F_NWR    = 18'h10000,
        ST_DONE     = 18'h20000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = soa_pkg::CMD_NOP;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = soa_pkg::CMD_ACCEPT;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (!flags.op_free)
                begin
                    if (flags.list_empty)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cmd        = soa_pkg::CMD_RD_HEAD;
                        state_next = ST_A_REC;
                    end
                end
                else if (flags.free_ok)
                begin
                    cmd        = soa_pkg::CMD_RD_P;
                    state_next = ST_F_REC;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (flags.scan_end)
                begin
                    cmd        = soa_pkg::CMD_FAIL;
                    state_next = ST_DONE;
                end
                else if (flags.scan_free)
                begin
                    cmd        = soa_pkg::CMD_FORM_START;
                    state_next = ST_FORM;
                end
                else
                begin
                    cmd = soa_pkg::CMD_SCAN_NEXT;
                end
            end
            ST_FORM:
            begin
                if (flags.form_more)
                begin
                    cmd = soa_pkg::CMD_FORM_STEP;
                end
                else
                begin
                    cmd        = soa_pkg::CMD_FORM_END;
                    state_next = ST_A_RD;
                end
            end
            ST_A_RD:
            begin
                cmd        = soa_pkg::CMD_RD_HEAD;
                state_next = ST_A_REC;
            end
            ST_A_REC:
            begin
                cmd        = soa_pkg::CMD_A_REC;
                state_next = ST_A_NFO;
            end
            ST_A_NFO:
            begin
                cmd        = soa_pkg::CMD_A_COMMIT;
                state_next = (flags.new_end && flags.n_valid) ? ST_A_LRD : ST_DONE;
            end
            ST_A_LRD:
            begin
                cmd        = soa_pkg::CMD_RD_T;
                state_next = ST_A_LWR;
            end
            ST_A_LWR:
            begin
                cmd        = soa_pkg::CMD_WR_PREV_NONE;
                state_next = ST_DONE;
            end
            ST_F_REC:
            begin
                cmd        = soa_pkg::CMD_F_REC;
                state_next = (flags.was_end && flags.h_valid) ? ST_F_HRD : ST_F_CHK;
            end
            ST_F_HRD:
            begin
                cmd        = soa_pkg::CMD_RD_T;
                state_next = ST_F_HWR;
            end
            ST_F_HWR:
            begin
                cmd        = soa_pkg::CMD_WR_PREV_P;
                state_next = ST_F_CHK;
            end
            ST_F_CHK:
            begin
                if (!flags.zero)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd = soa_pkg::CMD_RELEASE;
                    if (flags.p_is_head)
                    begin
                        state_next = flags.n_valid ? ST_F_NRD : ST_DONE;
                    end
                    else if (flags.v_valid)
                    begin
                        state_next = ST_F_VRD;
                    end
                    else
                    begin
                        state_next = flags.n_valid ? ST_F_NRD : ST_DONE;
                    end
                end
            end
            ST_F_VRD:
            begin
                cmd        = soa_pkg::CMD_RD_V;
                state_next = ST_F_VWR;
            end
            ST_F_VWR:
            begin
                cmd        = soa_pkg::CMD_WR_NEXT_N;
                state_next = flags.n_valid ? ST_F_NRD : ST_DONE;
            end
            ST_F_NRD:
            begin
                cmd        = soa_pkg::CMD_RD_N;
                state_next = ST_F_NWR;
            end
            ST_F_NWR:
            begin
                cmd        = soa_pkg::CMD_WR_PREV_REL;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (flags.out_space)
                begin
                    cmd        = soa_pkg::CMD_LOAD_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

@@ rtl/soa_datapath.sv @@
`timescale 1ns / 1ps

module soa_datapath #(
    parameter int PAGE_BYTES      = soa_pkg::PAGE_BYTES_DEF,
    parameter int POOL_PAGES      = soa_pkg::POOL_PAGES_DEF,
    parameter int SLOT_AREA_BYTES = soa_pkg::SLOT_AREA_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  soa_pkg::cmd_t               cmd,
    output soa_pkg::flags_t             flags,
    input  logic                        cfg_we,
    input  logic [soa_pkg::SIZE_W-1:0]  cfg_size,
    input  logic [soa_pkg::OP_W-1:0]    in_operation,
    input  logic [soa_pkg::ADDR_W-1:0]  in_address,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [soa_pkg::ADDR_W-1:0]  out_object_address,
    output logic                        out_status,
    output logic                        out_page_taken,
    output logic                        out_page_released
);
    localparam int OW      = $clog2(PAGE_BYTES);
    localparam int HW      = OW + 1;
    localparam int PW      = $clog2(POOL_PAGES + 1);
    localparam int PAW     = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam int WW      = OW + 2;
    localparam int CW      = soa_pkg::CNT_W;
    localparam int REC_W   = HW + CW + 2 * PW;
    localparam int N_DEPTH = POOL_PAGES * (PAGE_BYTES / 2);
    localparam int NAW     = (N_DEPTH > 1) ? $clog2(N_DEPTH) : 1;
    localparam int AREA    = (SLOT_AREA_BYTES > PAGE_BYTES) ? PAGE_BYTES : SLOT_AREA_BYTES;
    localparam int LIMIT   = ((PAGE_BYTES / 8) < AREA) ? (PAGE_BYTES / 8) : AREA;
    localparam int CMP_W   = 18;

    localparam logic [PW-1:0] NO_PAGE  = PW'(POOL_PAGES);
    localparam logic [HW-1:0] LIST_END = HW'(PAGE_BYTES);

    function automatic logic [NAW-1:0] nfo_addr(input logic [PW-1:0] pg,
                                                 input logic [OW-1:0] o);
        logic [PW+OW-2:0] w;
        w = {pg, o[OW-1:1]};
        return w[NAW-1:0];
    endfunction

    logic [soa_pkg::OP_W-1:0]   op_reg, op_next;
    logic                       free_ok_reg, free_ok_next;
    logic [PW-1:0]              p_reg, p_next;
    logic [OW-1:0]              off_reg, off_next;
    logic [PW-1:0]              t_reg, t_next;
    logic [CW-1:0]              rec_cnt_reg, rec_cnt_next;
    logic [PW-1:0]              rec_next_reg, rec_next_next;
    logic [PW-1:0]              rec_prev_reg, rec_prev_next;
    logic                       rel_head_reg, rel_head_next;
    logic [PW-1:0]              list_head_reg, list_head_next;
    logic [POOL_PAGES-1:0]      in_use_reg, in_use_next;
    logic [soa_pkg::SIZE_W-1:0] size_cfg_reg, size_cfg_next;
    logic [soa_pkg::SIZE_W-1:0] size_reg, size_next;
    logic [WW-1:0]              walk_reg, walk_next;
    logic [HW-1:0]              fhead_reg, fhead_next;
    logic [PW-1:0]              scan_reg, scan_next;
    logic [soa_pkg::ADDR_W-1:0] obj_reg, obj_next;
    logic                       status_reg, status_next;
    logic                       taken_reg, taken_next;
    logic                       released_reg, released_next;
    logic                       out_valid_reg, out_valid_next;
    logic [soa_pkg::ADDR_W-1:0] out_obj_reg, out_obj_next;
    logic                       out_status_reg, out_status_next;
    logic                       out_taken_reg, out_taken_next;
    logic                       out_released_reg, out_released_next;

    logic              p_we;
    logic [PAW-1:0]    p_waddr, p_raddr;
    logic [REC_W-1:0]  p_wdata, p_rdata;
    logic              n_we;
    logic [NAW-1:0]    n_waddr, n_raddr;
    logic [HW-1:0]     n_wdata, n_rdata;

    logic [HW-1:0]     rd_head;
    logic [CW-1:0]     rd_cnt;
    logic [PW-1:0]     rd_next, rd_prev;
    logic [PW-1:0]     n_clamp, v_clamp;
    logic [soa_pkg::ADDR_W:0] addr_page;
    logic [CMP_W-1:0]  cfg_wide;
    logic [soa_pkg::SIZE_W-1:0] eff_size;
    logic [WW:0]       walk_sum;
    logic [PW+OW:0]    obj_full;
    logic [CW-1:0]     cnt_dec;
    logic [PW-1:0]     new_next, new_prev;

    assign {rd_head, rd_cnt, rd_next, rd_prev} = p_rdata;
    assign n_clamp   = (rec_next_reg < NO_PAGE) ? rec_next_reg : NO_PAGE;
    assign v_clamp   = (rec_prev_reg < NO_PAGE) ? rec_prev_reg : NO_PAGE;
    assign addr_page = {1'b0, in_address} >> OW;
    assign cfg_wide  = CMP_W'(size_cfg_reg);
    assign walk_sum  = (WW+1)'(walk_reg) + (WW+1)'(size_reg);
    assign obj_full  = {1'b0, p_reg, {OW{1'b0}}} + (PW+OW+1)'(rd_head);
    assign cnt_dec   = rd_cnt - CW'(1);

    always_comb
    begin
        if (cfg_wide < CMP_W'(soa_pkg::MIN_SIZE))
        begin
            eff_size = soa_pkg::SIZE_W'(soa_pkg::MIN_SIZE);
        end
        else if (cfg_wide > CMP_W'(LIMIT))
        begin
            eff_size = soa_pkg::SIZE_W'(LIMIT);
        end
        else
        begin
            eff_size = size_cfg_reg;
        end
    end

    always_comb
    begin
        flags.op_free    = (op_reg == soa_pkg::OP_FREE);
        flags.free_ok    = free_ok_reg;
        flags.list_empty = (list_head_reg == NO_PAGE);
        flags.scan_end   = (scan_reg == NO_PAGE);
        flags.scan_free  = !in_use_reg[scan_reg[PAW-1:0]];
        flags.form_more  = (walk_sum <= (WW+1)'(AREA));
        flags.was_end    = (rd_head == LIST_END);
        flags.h_valid    = (list_head_reg != NO_PAGE);
        flags.new_end    = (n_rdata == LIST_END);
        flags.n_valid    = (rec_next_reg < NO_PAGE);
        flags.v_valid    = (rec_prev_reg < NO_PAGE);
        flags.zero       = (rec_cnt_reg == '0);
        flags.p_is_head  = (list_head_reg == p_reg);
        flags.out_space  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        op_next           = op_reg;
        free_ok_next      = free_ok_reg;
        p_next            = p_reg;
        off_next          = off_reg;
        t_next            = t_reg;
        rec_cnt_next      = rec_cnt_reg;
        rec_next_next     = rec_next_reg;
        rec_prev_next     = rec_prev_reg;
        rel_head_next     = rel_head_reg;
        list_head_next    = list_head_reg;
        in_use_next       = in_use_reg;
        size_cfg_next     = cfg_we ? cfg_size : size_cfg_reg;
        size_next         = size_reg;
        walk_next         = walk_reg;
        fhead_next        = fhead_reg;
        scan_next         = scan_reg;
        obj_next          = obj_reg;
        status_next       = status_reg;
        taken_next        = taken_reg;
        released_next     = released_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_obj_next      = out_obj_reg;
        out_status_next   = out_status_reg;
        out_taken_next    = out_taken_reg;
        out_released_next = out_released_reg;
        new_next          = rd_next;
        new_prev          = rd_prev;
        p_we              = 1'b0;
        p_waddr           = p_reg[PAW-1:0];
        p_wdata           = p_rdata;
        p_raddr           = p_reg[PAW-1:0];
        n_we              = 1'b0;
        n_waddr           = nfo_addr(p_reg, off_reg);
        n_wdata           = rd_head;
        n_raddr           = nfo_addr(p_reg, rd_head[OW-1:0]);

        case (cmd)
            soa_pkg::CMD_ACCEPT:
            begin
                op_next       = in_operation;
                p_next        = addr_page[PW-1:0];
                off_next      = in_address[OW-1:0];
                free_ok_next  = (addr_page < (soa_pkg::ADDR_W+1)'(POOL_PAGES)) &&
                                in_use_reg[addr_page[PAW-1:0]];
                obj_next      = '0;
                status_next   = 1'b0;
                taken_next    = 1'b0;
                released_next = 1'b0;
                scan_next     = '0;
            end
            soa_pkg::CMD_SCAN_NEXT:
            begin
                scan_next = scan_reg + PW'(1);
            end
            soa_pkg::CMD_FAIL:
            begin
                status_next = 1'b1;
            end
            soa_pkg::CMD_FORM_START:
            begin
                p_next     = scan_reg;
                walk_next  = '0;
                fhead_next = LIST_END;
                size_next  = eff_size;
            end
            soa_pkg::CMD_FORM_STEP:
            begin
                n_we       = 1'b1;
                n_waddr    = nfo_addr(p_reg, walk_reg[OW-1:0]);
                n_wdata    = fhead_reg;
                fhead_next = HW'(walk_reg);
                walk_next  = walk_sum[WW-1:0];
            end
            soa_pkg::CMD_FORM_END:
            begin
                p_we                        = 1'b1;
                p_wdata                     = {fhead_reg, CW'(0), NO_PAGE, NO_PAGE};
                in_use_next[p_reg[PAW-1:0]] = 1'b1;
                list_head_next              = p_reg;
                taken_next                  = 1'b1;
            end
            soa_pkg::CMD_RD_HEAD:
            begin
                p_raddr = list_head_reg[PAW-1:0];
                p_next  = list_head_reg;
            end
            soa_pkg::CMD_A_REC:
            begin
                rec_cnt_next  = rd_cnt;
                rec_next_next = rd_next;
                rec_prev_next = rd_prev;
                obj_next      = soa_pkg::ADDR_W'(obj_full);
            end
            soa_pkg::CMD_A_COMMIT:
            begin
                p_we          = 1'b1;
                p_wdata       = {n_rdata, rec_cnt_reg + CW'(1), rec_next_reg, rec_prev_reg};
                rec_cnt_next  = rec_cnt_reg + CW'(1);
                if (n_rdata == LIST_END)
                begin
                    list_head_next = n_clamp;
                    t_next         = n_clamp;
                end
            end
            soa_pkg::CMD_RD_T:
            begin
                p_raddr = t_reg[PAW-1:0];
            end
            soa_pkg::CMD_RD_P:
            begin
                p_raddr = p_reg[PAW-1:0];
            end
            soa_pkg::CMD_F_REC:
            begin
                n_we = 1'b1;
                if (rd_head == LIST_END)
                begin
                    new_next       = list_head_reg;
                    new_prev       = NO_PAGE;
                    t_next         = list_head_reg;
                    list_head_next = p_reg;
                end
                p_we          = 1'b1;
                p_wdata       = {HW'(off_reg), cnt_dec, new_next, new_prev};
                rec_cnt_next  = cnt_dec;
                rec_next_next = new_next;
                rec_prev_next = new_prev;
            end
            soa_pkg::CMD_WR_PREV_NONE, soa_pkg::CMD_WR_PREV_P, soa_pkg::CMD_WR_PREV_REL:
            begin
                if (cmd == soa_pkg::CMD_WR_PREV_NONE)
                begin
                    new_prev = NO_PAGE;
                end
                else if (cmd == soa_pkg::CMD_WR_PREV_P)
                begin
                    new_prev = p_reg;
                end
                else
                begin
                    new_prev = rel_head_reg ? NO_PAGE : v_clamp;
                end
                p_we    = 1'b1;
                p_waddr = t_reg[PAW-1:0];
                p_wdata = {rd_head, rd_cnt, rd_next, new_prev};
                if (t_reg == p_reg)
                begin
                    rec_prev_next = new_prev;
                end
            end
            soa_pkg::CMD_WR_NEXT_N:
            begin
                p_we    = 1'b1;
                p_waddr = t_reg[PAW-1:0];
                p_wdata = {rd_head, rd_cnt, n_clamp, rd_prev};
                if (t_reg == p_reg)
                begin
                    rec_next_next = n_clamp;
                end
            end
            soa_pkg::CMD_RELEASE:
            begin
                in_use_next[p_reg[PAW-1:0]] = 1'b0;
                released_next               = 1'b1;
                rel_head_next               = (list_head_reg == p_reg);
                if (list_head_reg == p_reg)
                begin
                    list_head_next = n_clamp;
                end
            end
            soa_pkg::CMD_RD_V:
            begin
                p_raddr = rec_prev_reg[PAW-1:0];
                t_next  = rec_prev_reg;
            end
            soa_pkg::CMD_RD_N:
            begin
                p_raddr = rec_next_reg[PAW-1:0];
                t_next  = rec_next_reg;
            end
            soa_pkg::CMD_LOAD_OUT:
            begin
                out_valid_next    = 1'b1;
                out_obj_next      = obj_reg;
                out_status_next   = status_reg;
                out_taken_next    = taken_reg;
                out_released_next = released_reg;
            end
            default:
            begin
                p_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_head_reg <= NO_PAGE;
            in_use_reg    <= '0;
            size_cfg_reg  <= soa_pkg::SIZE_W'(soa_pkg::SIZE_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            list_head_reg <= list_head_next;
            in_use_reg    <= in_use_next;
            size_cfg_reg  <= size_cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg           <= op_next;
        free_ok_reg      <= free_ok_next;
        p_reg            <= p_next;
        off_reg          <= off_next;
        t_reg            <= t_next;
        rec_cnt_reg      <= rec_cnt_next;
        rec_next_reg     <= rec_next_next;
        rec_prev_reg     <= rec_prev_next;
        rel_head_reg     <= rel_head_next;
        size_reg         <= size_next;
        walk_reg         <= walk_next;
        fhead_reg        <= fhead_next;
        scan_reg         <= scan_next;
        obj_reg          <= obj_next;
        status_reg       <= status_next;
        taken_reg        <= taken_next;
        released_reg     <= released_next;
        out_obj_reg      <= out_obj_next;
        out_status_reg   <= out_status_next;
        out_taken_reg    <= out_taken_next;
        out_released_reg <= out_released_next;
    end

    assign out_valid          = out_valid_reg;
    assign out_object_address = out_obj_reg;
    assign out_status         = out_status_reg;
    assign out_page_taken     = out_taken_reg;
    assign out_page_released  = out_released_reg;

    soa_ram #(
        .WIDTH (REC_W),
        .DEPTH (POOL_PAGES)
    ) u_page_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    soa_ram #(
        .WIDTH (HW),
        .DEPTH (N_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (n_wdata),
        .raddr (n_raddr),
        .rdata (n_rdata)
    );
endmodule

@@ rtl/slab_object_allocator.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Beat
// cfg      in   object_size
// req      in   operation, address
// rsp      out  object_address, status, page_taken, page_released
//
// An allocate from a partial slab takes the head slot of the list's first slab;
// when the slab fills, the next slab's link is patched. A free is ignored when
// its page is outside the pool or not in use, else it does neighbour record read-modify-writes.
// A fresh slab is found by a scan of the pages and formed by pushing each slot;
// an allocate with no free page ends the scan and fails.
// No clearing pass after reset. The result register lets a beat wait on rsp
// while the next req beat is taken; a second result holds the FSM until it frees.
module slab_object_allocator #(
    parameter int PAGE_BYTES      = soa_pkg::PAGE_BYTES_DEF,
    parameter int POOL_PAGES      = soa_pkg::POOL_PAGES_DEF,
    parameter int SLOT_AREA_BYTES = soa_pkg::SLOT_AREA_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    soa_cfg_if.sink    cfg,
    soa_req_if.sink    req,
    soa_rsp_if.source  rsp
);
    soa_pkg::cmd_t   cmd;
    soa_pkg::flags_t flags;

    assign cfg.ready = 1'b1;

    soa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .flags    (flags),
        .cmd      (cmd)
    );

    soa_datapath #(
        .PAGE_BYTES      (PAGE_BYTES),
        .POOL_PAGES      (POOL_PAGES),
        .SLOT_AREA_BYTES (SLOT_AREA_BYTES)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .flags              (flags),
        .cfg_we             (cfg.valid),
        .cfg_size           (cfg.object_size),
        .in_operation       (req.operation),
        .in_address         (req.address),
        .out_valid          (rsp.valid),
        .out_ready          (rsp.ready),
        .out_object_address (rsp.object_address),
        .out_status         (rsp.status),
        .out_page_taken     (rsp.page_taken),
        .out_page_released  (rsp.page_released)
    );
endmodule
